### hdl/fpr_pkg.sv
package fpr_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_RPM_LOW     = 2'd0;
   localparam logic [1:0] CSR_RPM_HIGH    = 2'd1;
   localparam logic [1:0] CSR_QUIET_LIMIT = 2'd2;

   localparam int RPM_BITS    = 13;
   localparam int DUTY_BITS   = 8;
   localparam int HUND_BITS   = 14;
   localparam int QUIET_BITS  = 16;
   localparam int TIMER_BITS  = 18;
   localparam int CSR_BITS    = 16;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
   localparam logic [QUIET_BITS-1:0] QUIET_MAX = '1;
   localparam logic [HUND_BITS-1:0]  HUND_FULL = 14'd10000;
   localparam logic [HUND_BITS-1:0]  HUND_LOW  = 14'd500;
   localparam logic [DUTY_BITS-1:0]  DUTY_FULL = 8'd255;
   localparam logic [DUTY_BITS-1:0]  DUTY_MIN  = 8'd50;
   localparam logic [RPM_BITS-1:0]   RPM_FLOOR = 13'd100;
   localparam int                    TACH_NUMER = 15000000;

   // (d-500)*205/9500 equals (d-500)*41/1900, done as a reciprocal multiply;
   // exact for d-500 up to 9500
   localparam logic [19:0]           MAP_RECIP   = 20'd724070;
   localparam int                    MAP_SHIFT   = 25;
   // x/255 as a reciprocal multiply, exact for x below 2^21
   localparam logic [21:0]           SCALE_RECIP = 22'd2105377;
   localparam int                    SCALE_SHIFT = 29;

   // what a tick did to the duty
   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_PERIOD,
      CMD_STATIC
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         level;
   } cmd_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_D,
      ST_MAP,
      ST_RPM,
      ST_SCALE,
      ST_DIV_H,
      ST_FIN
   } back_state_type;

endpackage

### hdl/fpr_front.sv
module fpr_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic                      in_level,
   input  logic [15:0]               quiet_limit,
   output logic                      in_ready,
   output logic                      cmd_valid,
   input  logic                      cmd_ready,
   output fpr_pkg::cmd_ctl_type      cmd_ctl,
   output logic [COUNT_BITS-1:0]     cmd_high,
   output logic [COUNT_BITS-1:0]     cmd_low
);
   import fpr_pkg::*;

   logic [COUNT_BITS-1:0] high_ff, high_in, low_ff, low_in;
   logic [QUIET_BITS-1:0] quiet_ff, quiet_in, limit;
   logic                  prev_ff;
   logic                  take;

   assign in_ready  = cmd_ready;
   assign cmd_valid = in_valid;
   assign take      = in_valid && cmd_ready;
   assign limit     = (quiet_limit == '0) ? QUIET_BITS'(1) : quiet_limit;

   // phase timing and classification of one tick
   always_comb begin
      high_in      = high_ff;
      low_in       = low_ff;
      quiet_in     = quiet_ff;
      cmd_ctl.kind = CMD_TICK;
      cmd_ctl.level = in_level;
      cmd_high     = high_ff;
      cmd_low      = low_ff;
      if (in_level != prev_ff) begin
         quiet_in = '0;
         if (in_level) begin
            if (high_ff != '0 && low_ff != '0) cmd_ctl.kind = CMD_PERIOD;
            high_in = '0;
            low_in  = '0;
         end
      end else if (quiet_ff != QUIET_MAX) begin
         quiet_in = quiet_ff + 1'b1;
      end
      if (in_level) begin
         if (high_in != '1) high_in = high_in + 1'b1;
      end else begin
         if (low_in != '1) low_in = low_in + 1'b1;
      end
      if (quiet_in >= limit) begin
         high_in      = '0;
         low_in       = '0;
         cmd_ctl.kind = CMD_STATIC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff  <= '0;
         low_ff   <= '0;
         quiet_ff <= '0;
         prev_ff  <= 1'b0;
      end else if (take) begin
         high_ff  <= high_in;
         low_ff   <= low_in;
         quiet_ff <= quiet_in;
         prev_ff  <= in_level;
      end
   end

endmodule

### hdl/fpr_queue.sv
module fpr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, rp_ff;
   logic [AW:0]      cnt_ff;
   logic             push, pop;

   assign wr_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
   end

   // pointers wrap at the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

endmodule

### hdl/fpr_div.sv
module fpr_div #(
   parameter int NW = 38,
   parameter int DW = 25
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot
);
   localparam int CW = $clog2(NW+1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] rem_ff, rem_in, den_ff;
   logic [DW:0]   shifted;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;

   assign done = done_ff;
   assign quot = q_ff;

   // one restoring step per cycle
   always_comb begin
      shifted = {rem_ff, q_ff[NW-1]};
      if (shifted >= {1'b0, den_ff}) begin
         rem_in = DW'(shifted - {1'b0, den_ff});
         q_in   = {q_ff[NW-2:0], 1'b1};
      end else begin
         rem_in = shifted[DW-1:0];
         q_in   = {q_ff[NW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CW'(1));
         if (start) cnt_ff <= CW'(NW);
         else if (cnt_ff != '0) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (cnt_ff != '0) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

endmodule

### hdl/fpr_back.sv
module fpr_back #(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  fpr_pkg::cmd_ctl_type  cmd_ctl,
   input  logic [COUNT_BITS-1:0] cmd_high,
   input  logic [COUNT_BITS-1:0] cmd_low,
   input  logic [12:0]           rpm_low,
   input  logic [12:0]           rpm_high,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_duty,
   output logic [7:0]            out_gate,
   output logic                  out_tach,
   output logic [12:0]           out_rpm,
   output logic [13:0]           out_hund
);
   import fpr_pkg::*;

   localparam int NW = (COUNT_BITS + 14 > 24) ? COUNT_BITS + 14 : 24;
   localparam int DW = (COUNT_BITS + 1 > 14) ? COUNT_BITS + 1 : 14;

   back_state_type state_ff, state_in;
   logic [DUTY_BITS-1:0]  duty_ff;
   logic [HUND_BITS-1:0]  hund_ff;
   logic [RPM_BITS-1:0]   rpm_ff;
   logic [TIMER_BITS-1:0] half_ff, timer_ff, timer_inc;
   logic                  phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_in;
   logic                  neg_ff;
   logic [20:0]           prod_ff;

   logic                  div_start, div_done;
   logic [NW-1:0]         div_num, div_quot;
   logic [DW-1:0]         div_den;
   logic                  pop, slot_free, load_out;

   logic [HUND_BITS-1:0]  d_val;
   logic [HUND_BITS-1:0]  map_off;
   logic [33:0]           map_prod;
   logic [DUTY_BITS:0]    map_val;
   logic signed [14:0]    diff;
   logic [12:0]           diff_mag;
   logic [20:0]           prod_mag;
   logic [42:0]           scale_prod;
   logic [RPM_BITS-1:0]   scale_q;
   logic signed [15:0]    rpm_base, rpm_step;
   logic signed [15:0]    rpm_sum;
   logic [RPM_BITS-1:0]   rpm_clamp;

   fpr_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign slot_free = !out_valid || out_ready;

   // datapath helpers
   always_comb begin
      d_val      = div_quot[HUND_BITS-1:0];
      map_off    = hund_ff - HUND_LOW;
      map_prod   = 34'(map_off) * 34'(MAP_RECIP);
      map_val    = 9'(DUTY_MIN) + 9'(map_prod >> MAP_SHIFT);
      diff       = 15'(signed'({2'b00, rpm_high})) - 15'(signed'({2'b00, rpm_low}));
      diff_mag   = diff[14] ? 13'(-diff) : diff[12:0];
      prod_mag   = 21'(duty_ff) * 21'(diff_mag);
      scale_prod = 43'(prod_ff) * 43'(SCALE_RECIP);
      scale_q    = 13'(scale_prod >> SCALE_SHIFT);
      rpm_base   = 16'({3'b000, rpm_low});
      rpm_step   = 16'({3'b000, scale_q});
      rpm_sum    = neg_ff ? rpm_base - rpm_step : rpm_base + rpm_step;
      if (rpm_sum < 16'sd100)       rpm_clamp = RPM_FLOOR;
      else if (rpm_sum > 16'sd8191) rpm_clamp = '1;
      else                          rpm_clamp = rpm_sum[12:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_ctl.kind)
                  CMD_PERIOD: state_in = ST_DIV_D;
                  CMD_STATIC: state_in = ST_RPM;
                  default:    state_in = ST_FIN;
               endcase
            end
         end
         ST_DIV_D: if (div_done) state_in = (d_val < HUND_LOW) ? ST_RPM : ST_MAP;
         ST_MAP:   state_in = ST_RPM;
         ST_RPM:   state_in = (duty_ff == '0) ? ST_FIN : ST_SCALE;
         ST_SCALE: state_in = ST_DIV_H;
         ST_DIV_H: if (div_done) state_in = ST_FIN;
         ST_FIN:   if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop       = 1'b0;
      load_out  = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (state_ff)
         ST_IDLE: begin
            pop = cmd_valid;
            if (cmd_valid && cmd_ctl.kind == CMD_PERIOD) begin
               div_start = 1'b1;
               div_num   = NW'(cmd_high) * NW'(HUND_FULL);
               div_den   = DW'(cmd_high) + DW'(cmd_low);
            end
         end
         ST_SCALE: begin
            div_start = 1'b1;
            div_num   = NW'(TACH_NUMER);
            div_den   = DW'(rpm_clamp);
         end
         ST_FIN:  load_out = slot_free;
         default: ;
      endcase
   end

   assign cmd_ready = pop;

   // tach step for the tick
   always_comb begin
      timer_inc = (timer_ff != TIMER_MAX) ? timer_ff + 1'b1 : timer_ff;
      timer_in  = timer_inc;
      phase_in  = phase_ff;
      if (rpm_ff != '0 && timer_inc >= half_ff) begin
         timer_in = '0;
         phase_in = ~phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         duty_ff   <= DUTY_FULL;
         hund_ff   <= '0;
         rpm_ff    <= '0;
         half_ff   <= '0;
         timer_ff  <= '0;
         phase_ff  <= 1'b0;
         neg_ff    <= 1'b0;
         prod_ff   <= '0;
         out_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && cmd_ctl.kind == CMD_STATIC) begin
                  duty_ff <= cmd_ctl.level ? DUTY_FULL : '0;
                  hund_ff <= cmd_ctl.level ? HUND_FULL : '0;
               end
            end
            ST_DIV_D: begin
               if (div_done) begin
                  hund_ff <= d_val;
                  if (d_val < HUND_LOW) duty_ff <= '0;
               end
            end
            ST_MAP: begin
               duty_ff <= (map_val > 9'(DUTY_FULL)) ? DUTY_FULL : map_val[7:0];
            end
            ST_RPM: begin
               neg_ff  <= diff[14];
               prod_ff <= prod_mag;
               if (duty_ff == '0) begin
                  rpm_ff  <= '0;
                  half_ff <= '0;
               end
            end
            ST_SCALE: rpm_ff <= rpm_clamp;
            ST_DIV_H: if (div_done) half_ff <= div_quot[TIMER_BITS-1:0];
            ST_FIN: begin
               if (slot_free) begin
                  timer_ff <= timer_in;
                  phase_ff <= phase_in;
               end
            end
            default: ;
         endcase
         if (load_out)       out_valid <= 1'b1;
         else if (out_ready) out_valid <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_duty <= duty_ff;
         out_gate <= DUTY_FULL - duty_ff;
         out_tach <= (rpm_ff != '0) ? phase_in : 1'b0;
         out_rpm  <= rpm_ff;
         out_hund <= hund_ff;
      end
   end

endmodule

### hdl/fan_pwm_remap_tach_emulator_core.sv
// Fan PWM remapper with tach emulation. Each req transfer is one microsecond
// tick carrying the sampled PWM level; each tick yields exactly one rsp
// transfer with the fan duty, gate drive, tach line state, fake rpm and last
// measured duty. A front stage times the high and low phases and classifies
// each tick; a four-entry queue feeds a back stage that does the remapping
// with one shared bit-serial divider of NW = COUNT_BITS+14 steps (at least
// 24). An ordinary tick goes straight to the back stage's finish state; a
// tick that closes a PWM period runs the duty divide, duty map, rpm scale
// and half period divide, or only the duty divide below 5 percent duty. A
// static high input runs the rpm scale and half period divide, a static low
// input neither; a busy result channel holds the finish state. Rpm settings
// apply at the next duty update, the quiet limit from the next tick.
module fan_pwm_remap_tach_emulator_core #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] pwm_level, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] fan_duty, [15:8] gate_drive,
                                    // [16] tach_pull_low, [29:17] fake_rpm,
                                    // [43:30] measured_duty, [47:44] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import fpr_pkg::*;

   localparam int QW = 3 + 2 * COUNT_BITS;

   logic [12:0]           rpm_low_ff, rpm_high_ff;
   logic [15:0]           quiet_ff;
   logic                  f_valid, f_ready, b_valid, b_ready;
   cmd_ctl_type           f_ctl, b_ctl;
   logic [COUNT_BITS-1:0] f_high, f_low, b_high, b_low;
   logic [QW-1:0]         b_data;
   logic [7:0]            o_duty, o_gate;
   logic                  o_tach;
   logic [12:0]           o_rpm;
   logic [13:0]           o_hund;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_low_ff  <= 13'd450;
         rpm_high_ff <= 13'd1800;
         quiet_ff    <= 16'd40000;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_RPM_LOW:     rpm_low_ff  <= csr_wdata[12:0];
            CSR_RPM_HIGH:    rpm_high_ff <= csr_wdata[12:0];
            CSR_QUIET_LIMIT: quiet_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   fpr_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_level    (req_tdata[0]),
      .quiet_limit (quiet_ff),
      .in_ready    (req_tready),
      .cmd_valid   (f_valid),
      .cmd_ready   (f_ready),
      .cmd_ctl     (f_ctl),
      .cmd_high    (f_high),
      .cmd_low     (f_low)
   );

   fpr_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  ({f_ctl, f_high, f_low}),
      .rd_valid (b_valid),
      .rd_ready (b_ready),
      .rd_data  (b_data)
   );

   assign b_ctl  = cmd_ctl_type'(b_data[QW-1 -: 3]);
   assign b_high = b_data[2*COUNT_BITS-1 -: COUNT_BITS];
   assign b_low  = b_data[COUNT_BITS-1:0];

   fpr_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (b_valid),
      .cmd_ready (b_ready),
      .cmd_ctl   (b_ctl),
      .cmd_high  (b_high),
      .cmd_low   (b_low),
      .rpm_low   (rpm_low_ff),
      .rpm_high  (rpm_high_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_duty  (o_duty),
      .out_gate  (o_gate),
      .out_tach  (o_tach),
      .out_rpm   (o_rpm),
      .out_hund  (o_hund)
   );

   assign rsp_tdata = {4'b0000, o_hund, o_rpm, o_tach, o_gate, o_duty};

endmodule

### tb/tb_checker.sv
module tb_checker
   import fpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          rsp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [HUND_BITS-1:0] measured;
      logic [RPM_BITS-1:0]  rpm;
      logic                 tach;
      logic [7:0]           gate;
      logic [7:0]           duty;
   } fan_out_type;

   localparam int CNT_MAX = 65535;

   // shadow registers and fan state
   int unsigned rpm_lo, rpm_hi, quiet_lim;
   int unsigned t_high, t_low, lvl_prev, quiet_cnt;
   int unsigned duty, hund, rpm, half_per, tach_tmr, tach_ph;
   fan_out_type fan_q[$];

   function automatic void remap_rpm();
      longint r;
      if (duty == 0) begin
         rpm = 0;
         half_per = 0;
      end else begin
         r = longint'(rpm_lo) + (longint'(duty) * (longint'(rpm_hi) - longint'(rpm_lo))) / 255;
         if (r < 100) r = 100;
         if (r > 8191) r = 8191;
         rpm = int'(r);
         half_per = TACH_NUMER / rpm;
      end
   endfunction

   function automatic fan_out_type fan_tick(int unsigned lvl);
      int unsigned lim;
      int unsigned d;
      int unsigned v;
      fan_out_type o;
      lim = (quiet_lim != 0) ? quiet_lim : 1;
      if (lvl != lvl_prev) begin
         quiet_cnt = 0;
         if (lvl != 0) begin
            // a complete period closes on the rising edge
            if (t_high != 0 && t_low != 0) begin
               d = (t_high * 10000) / (t_high + t_low);
               hund = d;
               if (d < 500) duty = 0;
               else begin
                  v = 50 + ((d - 500) * 205) / 9500;
                  if (v > 255) v = 255;
                  duty = v;
               end
               remap_rpm();
            end
            t_high = 0;
            t_low = 0;
         end
      end else if (quiet_cnt < 65535) quiet_cnt++;
      lvl_prev = lvl;
      if (lvl != 0) begin
         if (t_high < CNT_MAX) t_high++;
      end else if (t_low < CNT_MAX) t_low++;
      // static input
      if (quiet_cnt >= lim) begin
         t_high = 0;
         t_low = 0;
         duty = lvl ? 255 : 0;
         hund = lvl ? 10000 : 0;
         remap_rpm();
      end
      if (tach_tmr < 32'h3FFFF) tach_tmr++;
      if (rpm > 0 && tach_tmr >= half_per) begin
         tach_ph ^= 1;
         tach_tmr = 0;
      end
      o.duty = duty[7:0];
      o.gate = 8'(255 - duty);
      o.tach = (rpm > 0) ? tach_ph[0] : 1'b0;
      o.rpm = rpm[RPM_BITS-1:0];
      o.measured = hund[HUND_BITS-1:0];
      return o;
   endfunction

   assign pending = fan_q.size();

   always @(posedge clock) begin
      fan_out_type got, want;
      if (reset) begin
         rpm_lo <= 450; rpm_hi <= 1800; quiet_lim <= 40000;
         t_high = 0; t_low = 0; lvl_prev = 0; quiet_cnt = 0;
         duty = 255; hund = 0; rpm = 0; half_per = 0; tach_tmr = 0; tach_ph = 0;
         fan_q.delete();
         fail_count <= 0;
         rsp_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_RPM_LOW:     rpm_lo <= csr_wdata[12:0];
               CSR_RPM_HIGH:    rpm_hi <= csr_wdata[12:0];
               CSR_QUIET_LIMIT: quiet_lim <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) fan_q.push_back(fan_tick(req_tdata[0]));
         // compare each result transfer with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            rsp_count <= rsp_count + 1;
            got = rsp_tdata[43:0];
            if (fan_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected transfer %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = fan_q.pop_front();
               if (got !== want || rsp_tdata[47:44] !== 4'd0) begin
                  if (fail_count < 10)
                     $display("mismatch #%0d: duty %0d/%0d gate %0d/%0d tach %0d/%0d rpm %0d/%0d hund %0d/%0d",
                        rsp_count, want.duty, got.duty, want.gate, got.gate, want.tach, got.tach,
                        want.rpm, got.rpm, want.measured, got.measured);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### tb/tb_top.sv
module tb_top;
   import fpr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 0;
   logic [1:0]  csr_addr = CSR_RPM_LOW;
   logic [15:0] csr_wdata = 0;
   int          fail_count, pending, rsp_count;
   int          tick_count = 0;
   int          cycle = 0;
   bit          hold_off = 0;

   always #6 clock = ~clock;

   fan_pwm_remap_tach_emulator_core u_dut (.*);

   tb_checker u_chk (.*);

   // receiver stall pattern, plus one long hold-off
   always @(posedge clock) begin
      int ph;
      ph = cycle % 300;
      if (hold_off) rsp_tready <= 0;
      else if (ph < 60) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 900000) begin
         $display("timeout at %0d cycles", cycle);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_tick(input logic lvl, input bit gap);
      req_tvalid <= 1;
      req_tdata <= {7'd0, lvl};
      do @(posedge clock); while (!req_tready);
      tick_count++;
      if (gap) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // burst of pwm periods; high and low lengths in ticks
   task automatic send_pwm(input int periods, input int hi, input int lo, input bit rnd);
      int gap;
      for (int p = 0; p < periods; p++) begin
         gap = rnd ? ($urandom_range(0, 9) == 0) : 0;
         for (int k = 0; k < hi; k++) send_tick(1, gap && ($urandom_range(0, 3) == 0));
         for (int k = 0; k < lo; k++) send_tick(0, gap && ($urandom_range(0, 3) == 0));
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] v);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   initial begin
      int hi, lo;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: short quiet limit, full-scale and threshold duties
      csr_write(CSR_QUIET_LIMIT, 16'd1);
      send_pwm(1, 3, 0, 0);
      send_pwm(1, 0, 3, 0);
      drain();
      csr_write(CSR_QUIET_LIMIT, 16'd0);
      csr_write(CSR_RPM_LOW, 13'd100);
      csr_write(CSR_RPM_HIGH, 13'd5000);
      send_pwm(2, 1, 1, 0);
      drain();
      csr_write(CSR_QUIET_LIMIT, 16'd30);
      send_pwm(1, 1, 19, 0);   // just at 5 percent
      send_pwm(1, 1, 20, 0);   // below 5 percent
      send_pwm(1, 19, 1, 0);
      drain();
      // long hold-off while ticks keep coming
      csr_write(CSR_QUIET_LIMIT, 16'd65535);
      csr_write(CSR_RPM_LOW, 13'd4999);
      csr_write(CSR_RPM_HIGH, 13'd101);
      fork
         begin hold_off = 1; repeat (400) @(posedge clock); hold_off = 0; end
         send_pwm(6, 5, 7, 0);
      join
      drain();
      // random phases across register settings
      while (tick_count < 1400) begin
         csr_write(CSR_RPM_LOW, 13'($urandom_range(100, 4999)));
         csr_write(CSR_RPM_HIGH, 13'($urandom_range(101, 8191)));
         csr_write(CSR_QUIET_LIMIT, 16'($urandom_range(1, 60)));
         repeat ($urandom_range(2, 4)) begin
            hi = $urandom_range(0, 25);
            lo = $urandom_range(0, 25);
            send_pwm($urandom_range(1, 4), hi, lo, 1);
            if ($urandom_range(0, 4) == 0) send_pwm(1, $urandom_range(0, 70), 0, 1);
         end
         drain();
      end
      // long high phase at the slowest tach
      csr_write(CSR_QUIET_LIMIT, 16'd65535);
      csr_write(CSR_RPM_LOW, 13'd100);
      csr_write(CSR_RPM_HIGH, 13'd101);
      send_pwm(1, 300, 3, 0);
      send_pwm(1, 2, 2, 0);
      drain();
      $display("covered %0d ticks, %0d results checked, over several rpm and quiet settings",
         tick_count, rsp_count);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
